[src/crcf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcf_pkg: shared types and constants of the CRC-16 packet framer
// Payload structs, the job descriptor passed from front to back, and limits.
// ----------------------------------------------------------------------------
package crcf_pkg;

  localparam logic [7:0]  CHUNK_MAX   = 8'd255;
  localparam logic [15:0] MAX_MESSAGE = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [7:0]  START_RST   = 8'h01;
  localparam logic [7:0]  END_RST     = 8'h04;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic {
    CFG_START = 1'b0,
    CFG_END   = 1'b1
  } crcf_cfg_e;

  typedef enum logic [2:0] {
    ST_HEAD,
    ST_LEN,
    ST_DATA,
    ST_CRC_HI,
    ST_CRC_LO,
    ST_END_A,
    ST_END_B
  } crcf_step_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] remaining;
  } crcf_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } crcf_out_t;

  typedef struct packed {
    logic        hdr;
    logic [7:0]  len;
    logic        pay;
    logic [7:0]  data;
    logic        trl;
    logic [15:0] crc;
  } crcf_job_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
  } crcf_cfg_t;

endpackage

[src/crc16_packet_framer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_packet_framer: CRC-16 packet framer, top level
// Wraps a byte stream into start/length/payload/CRC/end frames.
//
//   channel  | signals                              | role
//   ---------+--------------------------------------+---------------------------
//   in       | in_valid_i, in_ready_o, in_data_i    | message bytes, empty msgs
//   out      | out_valid_o, out_ready_i, out_data_o | framed byte stream
//   cfg      | cfg_we_i, cfg_idx_i, cfg_wdata_i     | start and end byte regs
//
// One input transfer a cycle while the job queue has room; each job leaves
// as 1 to 7 output transfers, one a cycle from the output register unless
// out_ready_i stalls. An item's first byte is queued, then put in that register.
// Header and trailer bytes back up into the job queue (QUEUE_DEPTH jobs).
// Reset clears chunk position, CRC, queue and output valid; no clearing pass.
// ----------------------------------------------------------------------------
module crc16_packet_framer #(
  parameter int unsigned QUEUE_DEPTH = crcf_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  crcf_pkg::crcf_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output crcf_pkg::crcf_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [7:0]          cfg_wdata_i
);
  import crcf_pkg::*;

  crcf_cfg_t cfg_q;
  logic      q_full;
  logic      q_empty;
  logic      q_push;
  logic      q_pop;
  crcf_job_t q_job;
  crcf_job_t q_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte <= START_RST;
      cfg_q.end_byte   <= END_RST;
    end else if (cfg_we_i) begin
      unique case (crcf_cfg_e'(cfg_idx_i))
        CFG_START: cfg_q.start_byte <= cfg_wdata_i;
        CFG_END:   cfg_q.end_byte   <= cfg_wdata_i;
        default:   cfg_q.end_byte   <= cfg_q.end_byte;
      endcase
    end
  end

  crcf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (q_job)
  );

  crcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (q_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (q_head)
  );

  crcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[src/crcf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcf_front: item classifier
// Tracks chunk position and running CRC, turns each data item, and each
// empty-message item outside a chunk, into a frame job.
module crcf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  crcf_pkg::crcf_in_t in_data_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output crcf_pkg::crcf_job_t q_job_o
);
  import crcf_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic [7:0]  left_q, left_d;
  logic        accept;
  logic [15:0] rem_sat;
  logic [15:0] rem_one;
  logic [7:0]  chunk_len;
  logic [7:0]  left_cur;
  logic [7:0]  left_nxt;
  logic [15:0] crc_base;
  logic [15:0] crc_new;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    rem_sat   = (in_data_i.remaining > MAX_MESSAGE) ? MAX_MESSAGE : in_data_i.remaining;
    rem_one   = (rem_sat == 16'd0) ? 16'd1 : rem_sat;
    chunk_len = (rem_one > {8'h00, CHUNK_MAX}) ? CHUNK_MAX : rem_one[7:0];
    left_cur  = (left_q == 8'd0) ? chunk_len : left_q;
    crc_base  = (left_q == 8'd0) ? 16'h0000 : crc_q;
    crc_new   = crc_byte(crc_base, in_data_i.data_byte);
    left_nxt  = left_cur - 8'd1;
  end

  always_comb begin
    q_push_o = 1'b0;
    q_job_o  = '0;
    crc_d    = crc_q;
    left_d   = left_q;
    if (accept) begin
      if (in_data_i.kind) begin
        if (left_q == 8'd0) begin
          q_push_o    = 1'b1;
          q_job_o.hdr = 1'b1;
          q_job_o.trl = 1'b1;
        end
      end else begin
        q_push_o     = 1'b1;
        q_job_o.hdr  = (left_q == 8'd0);
        q_job_o.len  = chunk_len;
        q_job_o.pay  = 1'b1;
        q_job_o.data = in_data_i.data_byte;
        q_job_o.trl  = (left_nxt == 8'd0);
        q_job_o.crc  = crc_new;
        crc_d        = (left_nxt == 8'd0) ? 16'h0000 : crc_new;
        left_d       = left_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= '0;
      left_q <= '0;
    end else begin
      crc_q  <= crc_d;
      left_q <= left_d;
    end
  end

endmodule

[src/crcf_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcf_queue: job queue
// Small first-in first-out store between classifier and byte sequencer.
// ----------------------------------------------------------------------------
module crcf_queue #(
  parameter int unsigned DEPTH = crcf_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  crcf_pkg::crcf_job_t push_job_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output crcf_pkg::crcf_job_t head_o
);
  import crcf_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  crcf_job_t       mem_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[src/crcf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcf_back: frame byte sequencer
// Walks the head job through header, payload and trailer, one byte a cycle
// unless out_ready_i stalls the output.
module crcf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  crcf_pkg::crcf_cfg_t cfg_i,
  input  logic                q_empty_i,
  input  crcf_pkg::crcf_job_t q_head_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output crcf_pkg::crcf_out_t out_data_o
);
  import crcf_pkg::*;

  crcf_step_e state_q, state_d;
  crcf_step_e cur;
  crcf_step_e nxt;
  logic       has_nxt;
  logic       load;
  logic [7:0] byte_sel;
  logic       valid_q, valid_d;
  crcf_out_t  data_q, data_d;

  assign load = !q_empty_i && (!valid_q || out_ready_i);

  always_comb begin
    if (state_q != ST_HEAD) begin
      cur = state_q;
    end else if (q_head_i.hdr) begin
      cur = ST_HEAD;
    end else if (q_head_i.pay) begin
      cur = ST_DATA;
    end else begin
      cur = ST_CRC_HI;
    end
  end

  always_comb begin
    nxt     = ST_HEAD;
    has_nxt = 1'b1;
    unique case (cur)
      ST_HEAD:   nxt = ST_LEN;
      ST_LEN: begin
        if (q_head_i.pay) begin
          nxt = ST_DATA;
        end else if (q_head_i.trl) begin
          nxt = ST_CRC_HI;
        end else begin
          has_nxt = 1'b0;
        end
      end
      ST_DATA: begin
        if (q_head_i.trl) begin
          nxt = ST_CRC_HI;
        end else begin
          has_nxt = 1'b0;
        end
      end
      ST_CRC_HI: nxt = ST_CRC_LO;
      ST_CRC_LO: nxt = ST_END_A;
      ST_END_A:  nxt = ST_END_B;
      ST_END_B:  has_nxt = 1'b0;
      default:   has_nxt = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    if (load) begin
      state_d = has_nxt ? nxt : ST_HEAD;
    end
  end

  always_comb begin
    unique case (cur)
      ST_HEAD:   byte_sel = cfg_i.start_byte;
      ST_LEN:    byte_sel = q_head_i.len;
      ST_DATA:   byte_sel = q_head_i.data;
      ST_CRC_HI: byte_sel = q_head_i.crc[15:8];
      ST_CRC_LO: byte_sel = q_head_i.crc[7:0];
      ST_END_A:  byte_sel = cfg_i.end_byte;
      ST_END_B:  byte_sel = cfg_i.end_byte;
      default:   byte_sel = cfg_i.end_byte;
    endcase
    q_pop_o = load && !has_nxt;
    valid_d = load ? 1'b1 : (valid_q && !out_ready_i);
    data_d  = load ? crcf_out_t'{out_byte: byte_sel, last: !has_nxt} : data_q;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HEAD;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

endmodule

[src/crcf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcf_checker: port-level checks of the packet framer
// Output handshake rules, back-pressure coupling and reset behaviour.
// ----------------------------------------------------------------------------
module crcf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input crcf_pkg::crcf_out_t out_data_o
);

  a_out_valid_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped before transfer");

  a_out_data_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  a_full_needs_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled while output register empty");

  a_reset_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o && in_ready_o)
    else $error("output or back-pressure active right after reset");

endmodule

bind crc16_packet_framer crcf_checker u_crcf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
